// File: rtl/cops_pkg.sv
// ----------------------------------------------------------------------------
// cops_pkg
// Shared types and constants of the circle overlay pixel shader.
// ----------------------------------------------------------------------------
`default_nettype none

package cops_pkg;

  localparam int PIXEL_W     = 9;
  localparam int SLOT_W      = 6;
  localparam int CENTRE_W    = 24;
  localparam int RADIUS_W    = 23;
  localparam int CHAR_W      = 8;
  localparam int COUNT_W     = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COUNT      = 1'b1;

  localparam logic [CHAR_W-1:0] BACKGROUND_RESET = 8'd32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                       op;
    logic [SLOT_W-1:0]          slot;
    logic                       outline;
    logic signed [CENTRE_W-1:0] centre_x;
    logic signed [CENTRE_W-1:0] centre_y;
    logic [RADIUS_W-1:0]        radius;
    logic [CHAR_W-1:0]          paint_char;
    logic [PIXEL_W-1:0]         pixel_x;
    logic [PIXEL_W-1:0]         pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] pixel_char;
    logic              covered;
  } out_word_t;

  typedef struct packed {
    logic                       outline;
    logic signed [CENTRE_W-1:0] centre_x;
    logic signed [CENTRE_W-1:0] centre_y;
    logic [RADIUS_W-1:0]        radius;
    logic [CHAR_W-1:0]          paint;
  } circle_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_tag_t;

endpackage

`default_nettype wire

// File: rtl/circle_overlay_pixel_shader_unit.sv
// ----------------------------------------------------------------------------
// circle_overlay_pixel_shader_unit
// Circle table with a per-pixel coverage walk in draw order.
// ----------------------------------------------------------------------------
// A load word writes one table slot. A query word walks slots 0 to n-1, with
// n the circle count capped at MAX_CIRCLES, reading one table entry per cycle
// from the single read port; the entries flow through a five-stage coverage
// pipeline, and the block takes no new word from acceptance to result (with n
// zero it skips the walk). The result word sits in an output register, and the
// next word is accepted while it waits.
`default_nettype none

module circle_overlay_pixel_shader_unit import cops_pkg::*; #(
  parameter int MAX_CIRCLES = 64,
  parameter int FRAC_BITS   = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_word_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_word_t                   out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int LW = (COUNT_W > IW + 1) ? COUNT_W : IW + 1;

  typedef enum logic [1:0] {IDLE, WALK, FINISH} state_t;

  state_t             state;
  logic [CHAR_W-1:0]  background_char;
  logic [COUNT_W-1:0] circle_count;
  logic [LW-1:0]      count_sat, walk_n;
  logic [IW-1:0]      issue_idx;
  logic               issuing;
  logic [PIXEL_W-1:0] qx, qy;
  logic               cov_hit;
  logic [CHAR_W-1:0]  cov_char;

  logic       accept, load_we, rd_en, issue_last;
  circle_t    wr_entry, rd_entry;
  stage_tag_t rd_tag, res_tag;
  logic       res_cov;
  logic [CHAR_W-1:0] res_paint;

  assign in_ready   = (state == IDLE);
  assign accept     = in_valid && in_ready;
  assign load_we    = accept && (in_data.op == OP_LOAD) && (32'(in_data.slot) < MAX_CIRCLES);
  assign count_sat  = (LW'(circle_count) > LW'(MAX_CIRCLES)) ? LW'(MAX_CIRCLES)
                                                             : LW'(circle_count);
  assign rd_en      = (state == WALK) && issuing;
  assign issue_last = (LW'(issue_idx) + LW'(1)) == walk_n;

  assign wr_entry.outline  = in_data.outline;
  assign wr_entry.centre_x = in_data.centre_x;
  assign wr_entry.centre_y = in_data.centre_y;
  assign wr_entry.radius   = in_data.radius;
  assign wr_entry.paint    = in_data.paint_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      background_char <= BACKGROUND_RESET;
      circle_count    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BACKGROUND: background_char <= cfg_data;
        CFG_COUNT:      circle_count    <= cfg_data[COUNT_W-1:0];
        default:        ;
      endcase
    end
  end

  cops_table #(
    .DEPTH  (MAX_CIRCLES),
    .ADDR_W (IW)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (IW'(in_data.slot)),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (issue_idx),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag <= '0;
    end else begin
      rd_tag.valid <= rd_en;
      rd_tag.last  <= rd_en && issue_last;
    end
  end

  cops_cover #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cover (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (rd_tag),
    .entry   (rd_entry),
    .px      (qx),
    .py      (qy),
    .tag_out (res_tag),
    .cov     (res_cov),
    .paint   (res_paint)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      walk_n    <= '0;
      issue_idx <= '0;
      issuing   <= 1'b0;
      qx        <= '0;
      qy        <= '0;
      cov_hit   <= 1'b0;
      cov_char  <= '0;
      out_valid <= 1'b0;
      out_data  <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && (in_data.op == OP_QUERY)) begin
            walk_n    <= count_sat;
            issue_idx <= '0;
            issuing   <= (count_sat != '0);
            qx        <= in_data.pixel_x;
            qy        <= in_data.pixel_y;
            cov_hit   <= 1'b0;
            cov_char  <= background_char;
            state     <= (count_sat == '0) ? FINISH : WALK;
          end
        end
        WALK: begin
          if (issuing) begin
            if (issue_last) begin
              issuing <= 1'b0;
            end else begin
              issue_idx <= issue_idx + IW'(1);
            end
          end
          if (res_tag.valid) begin
            if (res_cov) begin
              cov_hit  <= 1'b1;
              cov_char <= res_paint;
            end
            if (res_tag.last) begin
              state <= FINISH;
            end
          end
        end
        FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.pixel_char <= cov_char;
            out_data.covered    <= cov_hit;
            state               <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/cops_table.sv
// ----------------------------------------------------------------------------
// cops_table
// Circle table: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cops_table import cops_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire circle_t           wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output circle_t                rdata
);

  circle_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/cops_cover.sv
// ----------------------------------------------------------------------------
// cops_cover
// Pipelined coverage test of one table entry against the queried pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module cops_cover import cops_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire stage_tag_t         tag_in,
  input  wire circle_t            entry,
  input  wire logic [PIXEL_W-1:0] px,
  input  wire logic [PIXEL_W-1:0] py,
  output stage_tag_t              tag_out,
  output logic                    cov,
  output logic [CHAR_W-1:0]       paint
);

  localparam int SW  = PIXEL_W + FRAC_BITS;
  localparam int MW  = (SW > CENTRE_W - 1) ? SW : CENTRE_W - 1;
  localparam int DW  = MW + 2;
  localparam int AW  = DW - 1;
  localparam int RW  = ((RADIUS_W > FRAC_BITS + 1) ? RADIUS_W : FRAC_BITS + 1) + 1;
  localparam int CW  = (2 * AW + 1 > 2 * RW) ? 2 * AW + 1 : 2 * RW;

  logic signed [DW-1:0] px_s, py_s, cx_s, cy_s, dx, dy;

  assign px_s = $signed(DW'(px) << FRAC_BITS);
  assign py_s = $signed(DW'(py) << FRAC_BITS);
  assign cx_s = DW'($signed(entry.centre_x));
  assign cy_s = DW'($signed(entry.centre_y));
  assign dx   = px_s - cx_s;
  assign dy   = py_s - cy_s;

  stage_tag_t          t1, t2, t3, t4, t5;
  logic [AW-1:0]       s1_adx, s1_ady, s2_ady;
  logic [2*AW-1:0]     s2_sx, s3_sx, s3_sy;
  logic [RADIUS_W-1:0] s1_r, s2_r, s3_r, s4_r;
  logic                s1_k, s2_k, s3_k, s4_k, s5_k;
  logic                s1_sm, s2_sm, s3_sm, s4_sm, s5_sm;
  logic [CHAR_W-1:0]   s1_p, s2_p, s3_p, s4_p, s5_p;
  logic [CW-1:0]       s4_d2, s4_rr, s5_d2, s5_rr, s5_hi, s5_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
      t4 <= '0;
      t5 <= '0;
    end else begin
      t1 <= tag_in;
      t2 <= t1;
      t3 <= t2;
      t4 <= t3;
      t5 <= t4;
    end
  end

  always_ff @(posedge clk) begin
    s1_adx <= dx[DW-1] ? AW'(-dx) : AW'(dx);
    s1_ady <= dy[DW-1] ? AW'(-dy) : AW'(dy);
    s1_r   <= entry.radius;
    s1_k   <= entry.outline;
    s1_sm  <= (entry.radius >> FRAC_BITS) == '0;
    s1_p   <= entry.paint;

    s2_sx  <= {{AW{1'b0}}, s1_adx} * {{AW{1'b0}}, s1_adx};
    s2_ady <= s1_ady;
    s2_r   <= s1_r;
    s2_k   <= s1_k;
    s2_sm  <= s1_sm;
    s2_p   <= s1_p;

    s3_sy  <= {{AW{1'b0}}, s2_ady} * {{AW{1'b0}}, s2_ady};
    s3_sx  <= s2_sx;
    s3_r   <= s2_r;
    s3_k   <= s2_k;
    s3_sm  <= s2_sm;
    s3_p   <= s2_p;

    s4_d2  <= CW'(s3_sx) + CW'(s3_sy);
    s4_rr  <= {{(CW-RADIUS_W){1'b0}}, s3_r} * {{(CW-RADIUS_W){1'b0}}, s3_r};
    s4_r   <= s3_r;
    s4_k   <= s3_k;
    s4_sm  <= s3_sm;
    s4_p   <= s3_p;

    s5_hi  <= s4_rr + (CW'(s4_r) << (FRAC_BITS + 1)) + (CW'(1) << (2 * FRAC_BITS));
    s5_lo  <= s4_rr - (CW'(s4_r) << (FRAC_BITS + 1)) + (CW'(1) << (2 * FRAC_BITS));
    s5_rr  <= s4_rr;
    s5_d2  <= s4_d2;
    s5_k   <= s4_k;
    s5_sm  <= s4_sm;
    s5_p   <= s4_p;
  end

  assign tag_out = t5;
  assign paint   = s5_p;
  assign cov     = s5_k ? ((s5_d2 < s5_hi) && (s5_sm || (s5_d2 > s5_lo)))
                        : (s5_d2 <= s5_rr);

endmodule

`default_nettype wire

// File: rtl/cops_checker.sv
// ----------------------------------------------------------------------------
// cops_checker
// Port-level assertions for the circle overlay pixel shader.
// ----------------------------------------------------------------------------
`default_nettype none

module cops_checker import cops_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire in_word_t               in_data,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire out_word_t              out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result word changed or dropped while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.op == OP_QUERY) |=> !in_ready)
    else $error("input accepted while a query walk is running");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.op == OP_LOAD && !out_valid) |=> !out_valid)
    else $error("load word produced a result word");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word appeared without a query in progress");

endmodule

bind circle_overlay_pixel_shader_unit cops_checker u_cops_checker (.*);

`default_nettype wire

// File: tb/circle_overlay_pixel_shader_unit_checker.sv
// ----------------------------------------------------------------------------
// circle_overlay_pixel_shader_unit_checker
// Watches the word channels and the register port of the circle overlay pixel
// shader. It keeps its own circle table and register copies, computes the
// character and coverage flag of every accepted query word, and compares them
// field by field with the result words in order.
// ----------------------------------------------------------------------------
module circle_overlay_pixel_shader_unit_checker import cops_pkg::*; #(
  parameter int MAX_CIRCLES = 64,
  parameter int FRAC_BITS   = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_word_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_word_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatch_count,
  output int                     shades_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  circle_t            circles [MAX_CIRCLES];
  logic [CHAR_W-1:0]  background;
  logic [COUNT_W-1:0] walk_count;
  out_word_t          expected_shades [$];
  int                 failures = 0;

  function automatic logic covers_pixel(circle_t c, logic [PIXEL_W-1:0] px,
                                        logic [PIXEL_W-1:0] py);
    longint one, dx, dy, d2, r, cx, cy, pxl, pyl;
    one = longint'(1) << FRAC_BITS;
    cx  = c.centre_x;
    cy  = c.centre_y;
    pxl = px;
    pyl = py;
    r   = c.radius;
    dx  = pxl * one - cx;
    dy  = pyl * one - cy;
    d2  = dx * dx + dy * dy;
    if (!c.outline) return d2 <= r * r;
    if (d2 >= (r + one) * (r + one)) return 1'b0;
    if (r >= one && d2 <= (r - one) * (r - one)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic out_word_t shade_pixel(logic [PIXEL_W-1:0] px,
                                            logic [PIXEL_W-1:0] py);
    out_word_t res;
    int        n;
    res.pixel_char = background;
    res.covered    = 1'b0;
    n = walk_count;
    if (n > MAX_CIRCLES) n = MAX_CIRCLES;
    for (int i = 0; i < n; i++) begin
      if (covers_pixel(circles[i], px, py)) begin
        res.pixel_char = circles[i].paint;
        res.covered    = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      background = BACKGROUND_RESET;
      walk_count = '0;
      expected_shades.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BACKGROUND: background = cfg_data[CHAR_W-1:0];
          CFG_COUNT:      walk_count = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.op == OP_LOAD) begin
          if (in_data.slot < MAX_CIRCLES) begin
            circles[in_data.slot].outline  = in_data.outline;
            circles[in_data.slot].centre_x = in_data.centre_x;
            circles[in_data.slot].centre_y = in_data.centre_y;
            circles[in_data.slot].radius   = in_data.radius;
            circles[in_data.slot].paint    = in_data.paint_char;
          end
        end else begin
          expected_shades.push_back(shade_pixel(in_data.pixel_x, in_data.pixel_y));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_shades.size() == 0) begin
          $error("result word with no query pending: pixel_char %0d, covered %0d",
                 out_data.pixel_char, out_data.covered);
          failures++;
        end else begin
          want = expected_shades.pop_front();
          if (out_data.pixel_char !== want.pixel_char) begin
            $error("pixel_char: expected %0d, got %0d", want.pixel_char,
                   out_data.pixel_char);
            failures++;
          end
          if (out_data.covered !== want.covered) begin
            $error("covered: expected %0d, got %0d", want.covered, out_data.covered);
            failures++;
          end
        end
      end
    end
    mismatch_count <= failures;
    shades_pending <= expected_shades.size();
  end

endmodule

// File: tb/circle_overlay_pixel_shader_unit_tb.sv
// ----------------------------------------------------------------------------
// circle_overlay_pixel_shader_unit_tb
// Drives load and query words into the circle overlay pixel shader with random
// gaps and output stalls, after a directed set of edge cases. Each phase sets
// the background character and the circle count while the block is idle, and
// only walks table slots that have been loaded. Checking is done by the
// checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module circle_overlay_pixel_shader_unit_tb import cops_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SIZE    = 64;
  localparam int FRAC_BITS     = 8;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 4000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_word_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_word_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_BACKGROUND;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  int                     mismatch_count;
  int                     shades_pending;

  circle_t placed [TABLE_SIZE];
  bit      loaded [TABLE_SIZE];
  bit      calm = 1'b0;
  int      idle_cycles = 0;

  always #10 clk = ~clk;

  circle_overlay_pixel_shader_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  circle_overlay_pixel_shader_unit_checker #(
    .MAX_CIRCLES (TABLE_SIZE),
    .FRAC_BITS   (FRAC_BITS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .shades_pending (shades_pending)
  );

  function automatic int idle_span();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 16);
    return $urandom_range(20, 150);
  endfunction

  function automatic in_word_t scrambled_word();
    in_word_t w;
    w.op         = 1'($urandom_range(0, 1));
    w.slot       = SLOT_W'($urandom_range(0, 63));
    w.outline    = 1'($urandom_range(0, 1));
    w.centre_x   = CENTRE_W'($urandom);
    w.centre_y   = CENTRE_W'($urandom);
    w.radius     = RADIUS_W'($urandom);
    w.paint_char = CHAR_W'($urandom_range(0, 255));
    w.pixel_x    = PIXEL_W'($urandom_range(0, 511));
    w.pixel_y    = PIXEL_W'($urandom_range(0, 511));
    return w;
  endfunction

  function automatic in_word_t load_word(int s, logic kind, longint cx, longint cy,
                                         longint r, logic [CHAR_W-1:0] paint);
    in_word_t w;
    w            = scrambled_word();
    w.op         = OP_LOAD;
    w.slot       = s[SLOT_W-1:0];
    w.outline    = kind;
    w.centre_x   = cx[CENTRE_W-1:0];
    w.centre_y   = cy[CENTRE_W-1:0];
    w.radius     = r[RADIUS_W-1:0];
    w.paint_char = paint;
    return w;
  endfunction

  function automatic in_word_t query_word(int px, int py);
    in_word_t w;
    w         = scrambled_word();
    w.op      = OP_QUERY;
    w.pixel_x = px[PIXEL_W-1:0];
    w.pixel_y = py[PIXEL_W-1:0];
    return w;
  endfunction

  // Most centres sit on or near the pixel grid so that circles actually cover pixels.
  function automatic longint random_centre();
    longint v;
    if ($urandom_range(0, 99) < 85) begin
      v = $urandom_range(0, 592 * 256 - 1);
      v = v - 40 * 256;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic in_word_t random_load(int s);
    longint cx, cy, r;
    int     p;
    cx = random_centre();
    cy = random_centre();
    p  = $urandom_range(0, 99);
    if (p < 50) r = $urandom_range(0, 40 * 256);
    else if (p < 85) r = $urandom_range(0, 300 * 256);
    else if (p < 95) r = $urandom;
    else begin
      case ($urandom_range(0, 4))
        0: r = 0;
        1: r = 1;
        2: r = 255;
        3: r = 256;
        default: r = 257;
      endcase
    end
    return load_word(s, 1'($urandom_range(0, 1)), cx, cy, r,
                     CHAR_W'($urandom_range(0, 255)));
  endfunction

  // About half the queries aim at or beside the rim or centre of a walked circle.
  function automatic in_word_t aimed_query(int walked);
    longint bx, by, rp, ox, oy;
    int     k, jig;
    in_word_t w;
    w = query_word($urandom_range(0, 511), $urandom_range(0, 511));
    if (walked > 0 && $urandom_range(0, 1) == 1) begin
      k  = $urandom_range(0, walked - 1);
      bx = placed[k].centre_x;
      by = placed[k].centre_y;
      rp = placed[k].radius;
      bx = bx >>> FRAC_BITS;
      by = by >>> FRAC_BITS;
      rp = rp >>> FRAC_BITS;
      ox = 0;
      oy = 0;
      case ($urandom_range(0, 4))
        0: ox = rp;
        1: ox = -rp;
        2: oy = rp;
        3: oy = -rp;
        default: ;
      endcase
      jig = $urandom_range(0, 2);
      ox  = ox + jig - 1;
      jig = $urandom_range(0, 2);
      oy  = oy + jig - 1;
      bx  = bx + ox;
      by  = by + oy;
      if (bx >= 0 && bx <= 511 && by >= 0 && by <= 511) begin
        w.pixel_x = bx[PIXEL_W-1:0];
        w.pixel_y = by[PIXEL_W-1:0];
      end
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    gap = idle_span();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (w.op == OP_LOAD) begin
      placed[w.slot].outline  = w.outline;
      placed[w.slot].centre_x = w.centre_x;
      placed[w.slot].centre_y = w.centre_y;
      placed[w.slot].radius   = w.radius;
      placed[w.slot].paint    = w.paint_char;
      loaded[w.slot]          = 1'b1;
    end
  endtask

  // Loads leave no result behind, so a fixed pause follows the last result.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (shades_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_registers(logic [CFG_DATA_W-1:0] bg, logic [CFG_DATA_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BACKGROUND;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_index <= CFG_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] bg, logic [CFG_DATA_W-1:0] count,
                           int items, bit quiet);
    int walked;
    walked = count[COUNT_W-1:0];
    if (walked > TABLE_SIZE) walked = TABLE_SIZE;
    for (int i = 0; i < walked; i++) begin
      if (!loaded[i]) send_word(random_load(i));
    end
    settle();
    write_registers(bg, count);
    calm = quiet;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < 25) send_word(random_load($urandom_range(0, 63)));
      else send_word(aimed_query(walked));
    end
    calm = 1'b0;
  endtask

  initial begin : sink
    int n;
    forever begin
      @(posedge clk);
      out_ready <= 1'b1;
      n = $urandom_range(1, 40);
      repeat (n) @(posedge clk);
      n = idle_span();
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("circle_overlay_pixel_shader_unit_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(query_word(0, 0));
    send_word(query_word(511, 511));
    send_word(load_word(0, 1'b0, 10 * 256, 10 * 256, 5 * 256, "A"));
    send_word(load_word(1, 1'b1, 5248, 2624, 3 * 256, "B"));
    send_word(load_word(2, 1'b0, 30 * 256, 30 * 256, 0, "C"));
    send_word(load_word(3, 1'b1, 40 * 256, 40 * 256, 0, "D"));
    send_word(load_word(4, 1'b1, 50 * 256, 50 * 256, 256, "E"));
    send_word(load_word(5, 1'b0, -8388608, 8388607, 8388607, 8'h00));
    send_word(load_word(6, 1'b0, 60 * 256, 60 * 256, 2 * 256, BACKGROUND_RESET));
    send_word(load_word(7, 1'b0, 0, 0, 8388607, 8'hFF));
    settle();
    write_registers(BACKGROUND_RESET, 8'd7);
    send_word(query_word(10, 10));
    send_word(query_word(15, 10));
    send_word(query_word(16, 10));
    send_word(query_word(23, 10));
    send_word(query_word(20, 10));
    send_word(query_word(30, 30));
    send_word(query_word(31, 30));
    send_word(query_word(40, 40));
    send_word(query_word(41, 40));
    send_word(query_word(50, 50));
    send_word(query_word(51, 50));
    send_word(query_word(60, 60));
    settle();
    write_registers(8'hFF, 8'd8);
    send_word(query_word(511, 0));
    send_word(query_word(0, 511));

    run_phase(8'h00, 8'd64, 185, 1'b0);
    run_phase(8'hFF, 8'd127, 185, 1'b0);
    run_phase(CFG_DATA_W'($urandom_range(0, 255)), 8'd1, 185, 1'b0);
    run_phase(CFG_DATA_W'($urandom_range(0, 255)), 8'hC0, 185, 1'b1);
    run_phase(CFG_DATA_W'($urandom_range(0, 255)), 8'd0, 60, 1'b0);
    run_phase(CFG_DATA_W'($urandom_range(0, 255)), 8'd65, 185, 1'b0);
    run_phase(CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(2, 63)),
              185, 1'b0);
    run_phase(CFG_DATA_W'($urandom_range(0, 255)), 8'd64, 185, 1'b1);
    run_phase(CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(0, 255)),
              185, 1'b0);
    run_phase(CFG_DATA_W'($urandom_range(0, 255)), 8'd16, 185, 1'b0);

    settle();
    if (mismatch_count == 0 && shades_pending == 0) begin
      $display("circle_overlay_pixel_shader_unit_tb: clean");
    end else begin
      $display("circle_overlay_pixel_shader_unit_tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cops_pkg.sv
rtl/cops_table.sv
rtl/cops_cover.sv
rtl/circle_overlay_pixel_shader_unit.sv
rtl/cops_checker.sv
tb/circle_overlay_pixel_shader_unit_checker.sv
tb/circle_overlay_pixel_shader_unit_tb.sv
